@@ rtl/s2i_pkg.sv @@
// Shared types and constants for the string to integer parser.
`default_nettype none

package s2i_pkg;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_SIGN,
		PH_ZERO,
		PH_XSEEN,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_NONE,
		ST_CONV,
		ST_OVF
	} status_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [15:0]        end_pos;
		logic               converted;
		logic               overflowed;
	} out_beat_t;

	// Parse state apart from the text positions, whose width follows the text length.
	typedef struct packed {
		phase_t      phase;
		status_t     status;
		logic        negative;
		logic [5:0]  eff_base;
		logic [63:0] accum;
	} state_t;

	localparam logic [5:0] RADIX_RESET = 6'd10;
	localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

	localparam state_t STATE_RESET = '{
		phase:    PH_SPACE,
		status:   ST_NONE,
		negative: 1'b0,
		eff_base: 6'd0,
		accum:    64'd0
	};

endpackage

`default_nettype wire

@@ rtl/s2i_step.sv @@
// Next-state and result logic for one text byte.
`default_nettype none

module s2i_step #(
	parameter longint unsigned MAX_TEXT_LEN = 65535,
	parameter int              PosW         = 16
) (
	input  s2i_pkg::state_t    st,
	input  logic [PosW-1:0]    pos,
	input  logic [PosW-1:0]    stop,
	input  logic [7:0]         ch,
	input  logic [5:0]         radix,
	output s2i_pkg::state_t    nx,
	output logic [PosW-1:0]    pos_nx,
	output logic [PosW-1:0]    stop_nx,
	output s2i_pkg::out_beat_t res
);

	localparam logic [PosW-1:0] MaxPos = PosW'(MAX_TEXT_LEN);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HT    = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [6:0] NO_DIGIT = 7'd99;

	function automatic logic [6:0] digit_of(input logic [7:0] c);
		logic [6:0] d;
		if (c >= CH_ZERO && c <= CH_NINE)
			d = 7'(c - CH_ZERO);
		else if (c >= CH_UA && c <= CH_UZ)
			d = 7'(c - CH_UA + 8'd10);
		else if (c >= CH_LA && c <= CH_LZ)
			d = 7'(c - CH_LA + 8'd10);
		else
			d = NO_DIGIT;
		return d;
	endfunction

	logic        in_range;
	logic        is_space;
	logic        start;
	logic        take;
	logic [5:0]  tbase;
	logic [6:0]  dig;
	logic [69:0] prod;
	logic [69:0] limit;
	logic [PosW-1:0] pos_inc;

	assign in_range = pos < MaxPos;
	assign is_space = (ch == CH_SPACE) || (ch >= CH_HT && ch <= CH_CR);
	assign dig      = digit_of(ch);
	assign limit    = st.negative ? 70'(s2i_pkg::LIM_NEG) : 70'(s2i_pkg::LIM_POS);
	assign pos_inc  = PosW'(pos + 1'b1);
	assign pos_nx   = in_range ? pos_inc : pos;

	always_comb begin
		nx      = st;
		stop_nx = stop;
		start   = 1'b0;
		take    = 1'b0;
		tbase   = st.eff_base;
		prod    = '0;
		if (in_range) begin
			case (st.phase)
				s2i_pkg::PH_SPACE: begin
					if (is_space) begin
						nx.phase = s2i_pkg::PH_SPACE;
					end else if (ch == CH_MINUS) begin
						nx.negative = 1'b1;
						nx.phase    = s2i_pkg::PH_SIGN;
					end else if (ch == CH_PLUS) begin
						nx.phase = s2i_pkg::PH_SIGN;
					end else begin
						start = 1'b1;
					end
				end
				s2i_pkg::PH_SIGN: begin
					start = 1'b1;
				end
				s2i_pkg::PH_ZERO: begin
					if (ch == CH_LX || ch == CH_UX) begin
						nx.eff_base = 6'd16;
						nx.phase    = s2i_pkg::PH_XSEEN;
					end else begin
						tbase = (st.eff_base == 6'd0) ? 6'd8 : 6'd16;
						take  = 1'b1;
					end
				end
				s2i_pkg::PH_XSEEN, s2i_pkg::PH_DIGITS: begin
					take = 1'b1;
				end
				default: begin
					nx.phase = s2i_pkg::PH_DONE;
				end
			endcase

			if (start) begin
				if (radix == 6'd1 || radix > 6'd36) begin
					nx.phase = s2i_pkg::PH_DONE;
				end else if (ch == CH_ZERO && (radix == 6'd0 || radix == 6'd16)) begin
					// a lone zero counts as converted; the prefix may still follow
					nx.eff_base = radix;
					nx.accum    = 64'd0;
					nx.status   = s2i_pkg::ST_CONV;
					nx.phase    = s2i_pkg::PH_ZERO;
					stop_nx     = pos_inc;
				end else begin
					tbase = (radix == 6'd0) ? 6'd10 : radix;
					take  = 1'b1;
				end
			end

			if (take) begin
				nx.eff_base = tbase;
				nx.phase    = s2i_pkg::PH_DIGITS;
				if (tbase < 6'd2 || dig >= {1'b0, tbase}) begin
					nx.phase = s2i_pkg::PH_DONE;
				end else begin
					stop_nx = pos_inc;
					if (st.status != s2i_pkg::ST_OVF) begin
						// accum * base + d > limit is the cutoff test in one compare
						prod = 70'(st.accum) * 70'(tbase) + 70'(dig);
						if (prod > limit) begin
							nx.accum  = limit[63:0];
							nx.status = s2i_pkg::ST_OVF;
						end else begin
							nx.accum  = prod[63:0];
							nx.status = s2i_pkg::ST_CONV;
						end
					end
				end
			end
		end else begin
			nx.phase = s2i_pkg::PH_DONE;
		end
	end

	logic [PosW+15:0] stop_ext;
	assign stop_ext = {16'd0, stop_nx};

	always_comb begin
		if (nx.status == s2i_pkg::ST_NONE) begin
			res = '0;
		end else begin
			res.value      = nx.negative ? -$signed(nx.accum) : $signed(nx.accum);
			res.end_pos    = stop_ext[15:0];
			res.converted  = 1'b1;
			res.overflowed = (nx.status == s2i_pkg::ST_OVF);
		end
	end

endmodule

`default_nettype wire

@@ rtl/string_to_integer_parser.sv @@
// Top level of the string to integer parser: byte register, parse state, result register.
`default_nettype none

// Converts a byte stream to a signed 64-bit integer in the manner of strtol: leading white
// space, one optional sign, 0x/0X prefix for radix 0 or 16, leading-zero octal for radix 0,
// saturation with an overflow flag. One result beat is produced for each byte marked last;
// it carries the value, the index of the first unconsumed byte (0 if nothing converted)
// and the flags. A byte is accepted every cycle unless a last byte is held; the rate is
// set by the parse state update, a single 64x6 multiply-add with a limit compare. The
// result is registered as the last byte leaves the input register; a last byte waits in
// the input register while an earlier result beat is still unaccepted. The radix register
// is written through cfg_we/cfg_wdata, by the user only while the block is idle (the block
// does not enforce this), and is latched per text at its first significant byte.
module string_to_integer_parser #(
	parameter longint unsigned MAX_TEXT_LEN = 65535
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire  [5:0]          cfg_wdata,
	input  wire                 in_valid,
	output logic                in_ready,
	input  s2i_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  wire                 out_ready,
	output s2i_pkg::out_beat_t  out_data
);

	localparam int PosW = $clog2(MAX_TEXT_LEN + 64'd1);

	logic [5:0]          radix_q;
	logic                valid_s1;
	s2i_pkg::in_beat_t   beat_s1;
	s2i_pkg::state_t     st_q;
	logic [PosW-1:0]     pos_q;
	logic [PosW-1:0]     stop_q;
	logic                out_valid_q;
	s2i_pkg::out_beat_t  out_data_q;

	s2i_pkg::state_t     st_nx;
	logic [PosW-1:0]     pos_nx;
	logic [PosW-1:0]     stop_nx;
	s2i_pkg::out_beat_t  res;
	logic                adv;

	// a byte without last needs no result slot
	assign adv      = valid_s1 && (!beat_s1.last || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	s2i_step #(
		.MAX_TEXT_LEN(MAX_TEXT_LEN),
		.PosW        (PosW)
	) u_step (
		.st     (st_q),
		.pos    (pos_q),
		.stop   (stop_q),
		.ch     (beat_s1.ch),
		.radix  (radix_q),
		.nx     (st_nx),
		.pos_nx (pos_nx),
		.stop_nx(stop_nx),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= s2i_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= s2i_pkg::STATE_RESET;
			pos_q  <= '0;
			stop_q <= '0;
		end else if (adv) begin
			if (beat_s1.last) begin
				st_q   <= s2i_pkg::STATE_RESET;
				pos_q  <= '0;
				stop_q <= '0;
			end else begin
				st_q   <= st_nx;
				pos_q  <= pos_nx;
				stop_q <= stop_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && beat_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && beat_s1.last) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_ovf_implies_conv: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_data_q.overflowed || out_data_q.converted))
		else $error("overflow reported without conversion");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q.converted) |->
			(out_data_q.value == 64'sd0 && out_data_q.end_pos == 16'd0))
		else $error("unconverted result is not zero");

	a_ovf_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.status == s2i_pkg::ST_OVF) |->
			(st_q.accum == (st_q.negative ? s2i_pkg::LIM_NEG : s2i_pkg::LIM_POS)))
		else $error("overflowed accumulator not at limit");

	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == s2i_pkg::PH_DONE && adv && !beat_s1.last) |=>
			(st_q.phase == s2i_pkg::PH_DONE))
		else $error("parse resumed after stopping");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(beat_s1)))
		else $error("stalled byte lost");

endmodule

`default_nettype wire
